@@ design/tws_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tws_pkg: shared types and constants of the trie word store
// Sizes of the node pool and alphabet, operation codes, link row type.
// ----------------------------------------------------------------------------
package tws_pkg;

   localparam int NODE_COUNT = 1024;
   localparam int NODE_W     = 10;   // bits of one node index
   localparam int FREE_W     = 11;   // node index plus room for NODE_COUNT
   localparam int ALPHA_SIZE = 26;
   localparam int LETTER_W   = 5;
   localparam int FUNC_W     = 2;

   localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_SEARCH = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_PREFIX = 2'd2;

   // all child links of one node, one entry per letter
   typedef logic [ALPHA_SIZE-1:0][NODE_W-1:0] link_row_type;

endpackage
`default_nettype wire

@@ design/trie_word_store_unit.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// trie_word_store_unit: prefix trie of lower-case words in a fixed node pool
// Takes one letter per request; insert, exact search or prefix test; one
// response when a word ends.
// ----------------------------------------------------------------------------
//
//   channel | ports                                          | direction
//   --------+------------------------------------------------+----------
//   request | req_valid req_ready req_func req_letter        | in
//           | req_last_letter req_empty_word                 |
//   result  | rsp_valid rsp_ready rsp_found rsp_pool_full    | out
//           | rsp_op_echo                                    |
//
// For a letter that does not end its word, the link row of the current node
// is read from the link memory, then written back if a fresh node is
// allocated, and the next node chosen. For a last letter the end mark of the
// final node is read from the mark memory after the link step; an empty word
// reads it directly. After reset a clearing pass over all NODE_COUNT (1024)
// rows zeroes both memories, one row a cycle; req_ready stays low meanwhile.
// A finished result waits in the output register; the block keeps taking
// letters while it waits and stalls only when the next word ends.
// ----------------------------------------------------------------------------
module trie_word_store_unit (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_ready,
   input  wire logic [tws_pkg::FUNC_W-1:0]   req_func,
   input  wire logic [tws_pkg::LETTER_W-1:0] req_letter,
   input  wire logic                        req_last_letter,
   input  wire logic                        req_empty_word,
   output logic                             rsp_valid,
   input  wire logic                        rsp_ready,
   output logic                             rsp_found,
   output logic                             rsp_pool_full,
   output logic [tws_pkg::FUNC_W-1:0]       rsp_op_echo
);
   import tws_pkg::*;

   // sequencer codes
   localparam logic [1:0] ST_CLEAR = 2'd0;  // zero the memories after reset
   localparam logic [1:0] ST_IDLE  = 2'd1;  // wait for a request
   localparam logic [1:0] ST_LINK  = 2'd2;  // link row valid: follow or allocate
   localparam logic [1:0] ST_MARK  = 2'd3;  // end mark valid: finish the word

   // memories: one link row and one end mark per node
   link_row_type link_mem [NODE_COUNT];
   logic         mark_mem [NODE_COUNT];

   logic [1:0]          state_ff,     state_in;
   logic [NODE_W-1:0]   clear_idx_ff, clear_idx_in;
   logic [NODE_W-1:0]   cur_node_ff,  cur_node_in;
   logic [FREE_W-1:0]   next_free_ff, next_free_in;
   logic                failed_ff,    failed_in;
   logic                full_ff,      full_in;

   // captured request
   logic [FUNC_W-1:0]   func_ff,   func_in;
   logic [LETTER_W-1:0] letter_ff, letter_in;
   logic                last_ff,   last_in;

   // result register
   logic                rsp_valid_ff, rsp_valid_in;
   logic                found_ff,     found_in;
   logic                pool_full_ff, pool_full_in;
   logic [FUNC_W-1:0]   op_echo_ff,   op_echo_in;

   // memory ports
   logic                link_re, link_we;
   logic [NODE_W-1:0]   link_ra, link_wa;
   link_row_type        link_wd, link_rd_ff;
   logic                mark_re, mark_we;
   logic [NODE_W-1:0]   mark_ra, mark_wa;
   logic                mark_wd, mark_rd_ff;

   logic                req_take;
   logic                load_ok;
   logic                letter_ok;
   logic [NODE_W-1:0]   link_sel;

   assign req_ready     = (state_ff == ST_IDLE);
   assign req_take      = req_valid && req_ready;
   assign load_ok       = !rsp_valid_ff || rsp_ready;
   assign letter_ok     = (letter_ff < LETTER_W'(ALPHA_SIZE));
   assign link_sel      = link_rd_ff[letter_ff];

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_found     = found_ff;
   assign rsp_pool_full = pool_full_ff;
   assign rsp_op_echo   = op_echo_ff;

   always_comb begin
      state_in     = state_ff;
      clear_idx_in = clear_idx_ff;
      cur_node_in  = cur_node_ff;
      next_free_in = next_free_ff;
      failed_in    = failed_ff;
      full_in      = full_ff;
      func_in      = func_ff;
      letter_in    = letter_ff;
      last_in      = last_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      found_in     = found_ff;
      pool_full_in = pool_full_ff;
      op_echo_in   = op_echo_ff;

      link_re = 1'b0;
      link_ra = cur_node_ff;
      link_we = 1'b0;
      link_wa = cur_node_ff;
      link_wd = link_rd_ff;
      mark_re = 1'b0;
      mark_ra = cur_node_ff;
      mark_we = 1'b0;
      mark_wa = cur_node_ff;
      mark_wd = 1'b1;

      case (state_ff)
         ST_CLEAR: begin
            // sweep both memories, one row a cycle
            link_we = 1'b1;
            link_wa = clear_idx_ff;
            link_wd = '0;
            mark_we = 1'b1;
            mark_wa = clear_idx_ff;
            mark_wd = 1'b0;
            clear_idx_in = clear_idx_ff + NODE_W'(1);
            if (clear_idx_ff == NODE_W'(NODE_COUNT - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_take) begin
               func_in   = req_func;
               letter_in = req_letter;
               last_in   = req_last_letter;
               if (req_empty_word) begin
                  // no letter: finish at the current node
                  mark_re  = 1'b1;
                  state_in = ST_MARK;
               end else begin
                  link_re  = 1'b1;
                  state_in = ST_LINK;
               end
            end
         end
         ST_LINK: begin
            if (!failed_ff) begin
               if (!letter_ok) begin
                  failed_in = 1'b1;
               end else if (link_sel != '0) begin
                  cur_node_in = link_sel;
               end else if (func_ff != FUNC_INSERT) begin
                  failed_in = 1'b1;
               end else if (next_free_ff >= FREE_W'(NODE_COUNT)) begin
                  // pool exhausted: abort, keep the partial path unmarked
                  failed_in = 1'b1;
                  full_in   = 1'b1;
               end else begin
                  // allocate a fresh node and write the row back
                  link_we  = 1'b1;
                  link_wd[letter_ff] = next_free_ff[NODE_W-1:0];
                  cur_node_in  = next_free_ff[NODE_W-1:0];
                  next_free_in = next_free_ff + FREE_W'(1);
               end
            end
            if (last_ff) begin
               mark_re  = 1'b1;
               mark_ra  = cur_node_in;
               state_in = ST_MARK;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_MARK: begin
            // hold here while the previous result is still waiting
            if (load_ok) begin
               rsp_valid_in = 1'b1;
               op_echo_in   = func_ff;
               pool_full_in = failed_ff && full_ff;
               if (failed_ff) begin
                  found_in = 1'b0;
               end else if (func_ff == FUNC_INSERT) begin
                  found_in = 1'b1;
                  mark_we  = 1'b1;
               end else if (func_ff == FUNC_SEARCH) begin
                  found_in = mark_rd_ff;
               end else begin
                  found_in = 1'b1;
               end
               cur_node_in = '0;
               failed_in   = 1'b0;
               full_in     = 1'b0;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clear_idx_ff <= '0;
         cur_node_ff  <= '0;
         next_free_ff <= FREE_W'(1);
         failed_ff    <= 1'b0;
         full_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clear_idx_ff <= clear_idx_in;
         cur_node_ff  <= cur_node_in;
         next_free_ff <= next_free_in;
         failed_ff    <= failed_in;
         full_ff      <= full_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff      <= func_in;
      letter_ff    <= letter_in;
      last_ff      <= last_in;
      found_ff     <= found_in;
      pool_full_ff <= pool_full_in;
      op_echo_ff   <= op_echo_in;
   end

   // link memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (link_we) begin
         link_mem[link_wa] <= link_wd;
      end
      if (link_re) begin
         link_rd_ff <= link_mem[link_ra];
      end
   end

   // end mark memory
   always_ff @(posedge clock) begin
      if (mark_we) begin
         mark_mem[mark_wa] <= mark_wd;
      end
      if (mark_re) begin
         mark_rd_ff <= mark_mem[mark_ra];
      end
   end

   // the allocator never passes the pool size
   a_free_bound: assert property (@(posedge clock) disable iff (reset)
      next_free_ff <= FREE_W'(NODE_COUNT))
      else $error("next free node beyond the pool");

   // the walk only ever stands on an allocated node
   a_cur_alloc: assert property (@(posedge clock) disable iff (reset)
      FREE_W'(cur_node_ff) < next_free_ff)
      else $error("current node not yet allocated");

   // a finished word leaves the walk at the root with no failure pending
   a_word_restart: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MARK && load_ok) |=>
         (cur_node_ff == '0 && !failed_ff && !full_ff && rsp_valid_ff))
      else $error("walk not restarted after a word");

   // an aborted insert never reports success
   a_full_not_found: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_pool_full) |-> !rsp_found)
      else $error("pool full together with found");

endmodule
`default_nettype wire
